FILE: hw/rtl/lognorm_pkg.sv
// Shared constants, types and the log lookup table for the log transform block.
// Used by lognorm_div and log_transform_minmax_normalize_unit; depends on nothing.
package lognorm_pkg;

  // Fraction bits of the log values, range 8 to 16.
  localparam int unsigned LOG_FRAC_BITS = 12;
  // ln(256) < 8, so three integer bits suffice.
  localparam int unsigned LOG_W         = LOG_FRAC_BITS + 3;
  localparam int unsigned SAMPLE_W      = 8;
  localparam int unsigned TABLE_DEPTH   = 256;
  localparam int unsigned RECIP_W       = 24;
  // Dividend 255 * 2^(F+8) plus half the divisor stays below 2^(F+16).
  localparam int unsigned NUM_W         = LOG_FRAC_BITS + 16;
  localparam int unsigned CNT_W         = $clog2(NUM_W + 1);
  localparam int unsigned PROD_W        = LOG_W + RECIP_W;
  localparam int unsigned OUT_SHIFT     = LOG_FRAC_BITS + 8;

  localparam logic [RECIP_W-1:0] RECIP_MAX  = {RECIP_W{1'b1}};
  localparam logic [NUM_W-1:0]   NUM_BASE   = NUM_W'(255) << (LOG_FRAC_BITS + 8);
  localparam logic [PROD_W:0]    ROUND_HALF = (PROD_W + 1)'(1) << (LOG_FRAC_BITS + 7);
  localparam logic [SAMPLE_W-1:0] OUT_MAX   = {SAMPLE_W{1'b1}};

  // Gain register codes.
  localparam logic signed [1:0] GAIN_ZERO = 2'sb00;
  localparam logic signed [1:0] GAIN_POS  = 2'sb01;
  localparam int unsigned       GAIN_NEG_BIT = 1;

  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  typedef logic [LOG_W-1:0] log_table_t [TABLE_DEPTH];

  // ln(x) for x in 1..256: log2 by repeated squaring of a Q30 mantissa,
  // then scaled by ln2 and rounded half up.
  function automatic logic [LOG_W-1:0] log_fixed(input logic [8:0] x);
    logic [63:0] k;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] log2q;
    logic [63:0] prod;
    k    = '0;
    frac = '0;
    for (int j = 1; j <= 8; j++) begin
      if ((x >> j) != 9'd0) begin
        k = 64'(j);
      end
    end
    m = 64'(x) << (30 - k);
    for (int i = 0; i < 24; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    log2q = (k << 24) | frac;
    prod  = log2q * LN2_Q32;
    prod  = (prod + (64'd1 << (55 - LOG_FRAC_BITS))) >> (56 - LOG_FRAC_BITS);
    return prod[LOG_W-1:0];
  endfunction

  function automatic log_table_t build_log_table();
    log_table_t tbl;
    for (int p = 0; p < TABLE_DEPTH; p++) begin
      tbl[p] = log_fixed(9'(p + 1));
    end
    return tbl;
  endfunction

  // Entry p holds ln(1 + p).
  localparam log_table_t LOG_TABLE = build_log_table();

endpackage

FILE: hw/rtl/lognorm_div.sv
// Restoring divider, one quotient bit per cycle, for the per-frame reciprocal.
// Depends on lognorm_pkg.
module lognorm_div
  import lognorm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [LOG_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [LOG_W-1:0] rem_q, rem_d;
  logic [LOG_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [LOG_W:0]   trial;
  logic [LOG_W-1:0] diff;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  // When the divisor fits, trial stays below twice the divisor, so the
  // difference fits in LOG_W bits.
  assign diff  = trial[LOG_W-1:0] - dvs_q;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      // Shift one dividend bit in, subtract when it fits.
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff;
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[LOG_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/log_transform_minmax_normalize_unit.sv
// Top level of the log intensity transform with min/max normalization.
// Depends on lognorm_pkg and lognorm_div.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+------------------------------------
//  input     | in_valid_i / in_ready_o     | mode_i, first_of_pass_i, sample_i
//  output    | out_valid_o / out_ready_i   | out_sample_o
//  config    | gain_sign_we_i (no wait)    | gain_sign_i
//
//  A measure word (mode 0) is absorbed in the cycle it is accepted; the next
//  word can follow at once. A map word (mode 1) steps through lookup,
//  prepare, multiply and output load, then back to idle. The first map word
//  of a pass with a positive log range also runs the bit-serial divider that
//  forms the range reciprocal, between prepare and multiply. The output load
//  waits while the output register is full and not being read; reset sets
//  control state, the gain (to positive) and the extremes only.
module log_transform_minmax_normalize_unit
  import lognorm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                gain_sign_we_i,
  input  logic signed [1:0]   gain_sign_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic                first_of_pass_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SAMPLE_W-1:0] out_sample_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic signed [1:0]   gain_q;
  logic [SAMPLE_W-1:0] smallest_q, largest_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                first_q;
  logic [LOG_W-1:0]    lp_q, lmin_q, lmax_q;
  logic [LOG_W-1:0]    n_q;
  logic [RECIP_W-1:0]  recip_q;
  logic [PROD_W-1:0]   prod_q;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;

  logic                in_acc;
  logic                out_load;
  logic                inverted;
  logic [LOG_W-1:0]    n_d;
  logic [LOG_W-1:0]    range_d;
  logic                range_pos;
  logic                div_start;
  logic                div_done;
  logic [NUM_W-1:0]    div_quo;
  logic [PROD_W:0]     rounded;
  logic [PROD_W:0]     scaled;
  logic [SAMPLE_W-1:0] mapped;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign inverted   = gain_q[GAIN_NEG_BIT];

  // Numerator and log range, from the registered lookups.
  assign range_pos = lmax_q > lmin_q;
  assign range_d   = lmax_q - lmin_q;
  always_comb begin
    if (inverted) begin
      n_d = (lmax_q > lp_q) ? (lmax_q - lp_q) : '0;
    end else begin
      n_d = (lp_q > lmin_q) ? (lp_q - lmin_q) : '0;
    end
  end

  assign div_start = (state_q == S_PREP) && first_q && range_pos;

  lognorm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (NUM_BASE + NUM_W'(range_d >> 1)),
    .divisor_i  (range_d),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Round half up, then saturate to the sample range.
  assign rounded = {1'b0, prod_q} + ROUND_HALF;
  assign scaled  = rounded >> OUT_SHIFT;
  assign mapped  = (scaled > (PROD_W + 1)'(OUT_MAX)) ? OUT_MAX : scaled[SAMPLE_W-1:0];

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Sequencer: advance one step per cycle, hold in the idle, divider and output steps.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc && mode_i) state_d = S_LOOK;
      S_LOOK: state_d = S_PREP;
      S_PREP: state_d = div_start ? S_DIV : S_MUL;
      S_DIV:  if (div_done) state_d = S_MUL;
      S_MUL:  state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gain_q      <= GAIN_POS;
      smallest_q  <= OUT_MAX;
      largest_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (gain_sign_we_i) begin
        gain_q <= gain_sign_i;
      end
      // Measure pass: restart extremes on the first word, else widen them.
      if (in_acc && !mode_i) begin
        if (first_of_pass_i) begin
          smallest_q <= sample_i;
          largest_q  <= sample_i;
        end else begin
          if (sample_i < smallest_q) smallest_q <= sample_i;
          if (sample_i > largest_q)  largest_q  <= sample_i;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
      first_q  <= first_of_pass_i;
    end
    if (state_q == S_LOOK) begin
      lp_q   <= LOG_TABLE[sample_q];
      lmin_q <= LOG_TABLE[smallest_q];
      lmax_q <= LOG_TABLE[largest_q];
    end
    if (state_q == S_PREP) begin
      n_q <= n_d;
      // Flat or inverted extremes give a zero reciprocal.
      if (first_q && !range_pos) begin
        recip_q <= '0;
      end
    end
    if ((state_q == S_DIV) && div_done) begin
      recip_q <= (|div_quo[NUM_W-1:RECIP_W]) ? RECIP_MAX : div_quo[RECIP_W-1:0];
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(n_q) * PROD_W'(recip_q);
    end
    if (out_load) begin
      out_sample_q <= (gain_q == GAIN_ZERO) ? '0 : mapped;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;

`ifndef SYNTH
  a_map_starts_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_i) |=> (state_q == S_LOOK))
    else $error("map word did not start the lookup step");

  a_measure_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !mode_i) |=> (state_q == S_IDLE))
    else $error("measure word left the idle state");

  a_first_sets_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !mode_i && first_of_pass_i) |=> (smallest_q == largest_q))
    else $error("first measure word did not restart both extremes");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  a_zero_gain_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (gain_q == GAIN_ZERO)) |=> (out_sample_o == '0))
    else $error("zero gain produced a nonzero word");
`endif

endmodule

FILE: sim/log_transform_minmax_normalize_unit_tb.sv
// Testbench for log_transform_minmax_normalize_unit: directed table, then random frames.
// Checks each output word against a local predictor of the log min/max map.
// Depends on lognorm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module log_transform_minmax_normalize_unit_tb
  import lognorm_pkg::*;
();

  // Pass codes on the mode input.
  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_MAP     = 1'b1;

  // Negative gain codes; both select the inverted map.
  localparam logic signed [1:0] GAIN_NEG     = 2'sb11;
  localparam logic signed [1:0] GAIN_NEG_ALT = 2'sb10;

  localparam longint unsigned LN2_SCALE = 64'd2977044472;  // round(ln2 * 2^32)

  // Cycles to let pass after the last result before touching the register.
  localparam int unsigned SETTLE_CYCLES = NUM_W + 8;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_WORDS   = 900;

  // Marks a table row whose output comes from the predictor.
  localparam logic signed [9:0] PREDICT = -10'sd1;

  typedef enum logic {ROW_WORD, ROW_GAIN} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              mode;
    logic              first;
    logic [7:0]        value;
    logic signed [1:0] gain;
    logic signed [9:0] want;
  } dir_row_t;

  // Directed walk: reset extremes, a 40..200 frame, gain codes, narrow, flat and full frames.
  localparam dir_row_t DIR_ROWS [30] = '{
    // map right after reset: extremes are inverted, reciprocal becomes 0
    '{ROW_WORD, MODE_MAP,     1'b1, 8'd100, GAIN_POS, 10'sd0},
    // measure pass 40..200, the first word restarts both extremes
    '{ROW_WORD, MODE_MEASURE, 1'b1, 8'd40,  GAIN_POS, PREDICT},
    '{ROW_WORD, MODE_MEASURE, 1'b0, 8'd200, GAIN_POS, PREDICT},
    '{ROW_WORD, MODE_MEASURE, 1'b0, 8'd40,  GAIN_POS, PREDICT},
    // map pass: min maps to 0, max to 255, outside values clamp and saturate
    '{ROW_WORD, MODE_MAP,     1'b1, 8'd40,  GAIN_POS, 10'sd0},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd200, GAIN_POS, 10'sd255},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd90,  GAIN_POS, PREDICT},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd0,   GAIN_POS, 10'sd0},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd255, GAIN_POS, 10'sd255},
    // inverted maps keep the stored reciprocal, then zero gain, then positive again
    '{ROW_GAIN, MODE_MEASURE, 1'b0, 8'd0,   GAIN_NEG, PREDICT},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd40,  GAIN_POS, 10'sd255},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd0,   GAIN_POS, 10'sd255},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd255, GAIN_POS, 10'sd0},
    '{ROW_GAIN, MODE_MEASURE, 1'b0, 8'd0,   GAIN_NEG_ALT, PREDICT},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd128, GAIN_POS, PREDICT},
    '{ROW_GAIN, MODE_MEASURE, 1'b0, 8'd0,   GAIN_ZERO, PREDICT},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd77,  GAIN_POS, 10'sd0},
    '{ROW_GAIN, MODE_MEASURE, 1'b0, 8'd0,   GAIN_POS, PREDICT},
    // narrowest range; the map word before the first uses the old reciprocal
    '{ROW_WORD, MODE_MEASURE, 1'b1, 8'd254, GAIN_POS, PREDICT},
    '{ROW_WORD, MODE_MEASURE, 1'b0, 8'd255, GAIN_POS, PREDICT},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd1,   GAIN_POS, PREDICT},
    '{ROW_WORD, MODE_MAP,     1'b1, 8'd255, GAIN_POS, 10'sd255},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd254, GAIN_POS, 10'sd0},
    // flat frame gives all zeros
    '{ROW_WORD, MODE_MEASURE, 1'b1, 8'd0,   GAIN_POS, PREDICT},
    '{ROW_WORD, MODE_MAP,     1'b1, 8'd0,   GAIN_POS, 10'sd0},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd255, GAIN_POS, 10'sd0},
    // full range frame
    '{ROW_WORD, MODE_MEASURE, 1'b1, 8'd0,   GAIN_POS, PREDICT},
    '{ROW_WORD, MODE_MEASURE, 1'b0, 8'd255, GAIN_POS, PREDICT},
    '{ROW_WORD, MODE_MAP,     1'b1, 8'd128, GAIN_POS, PREDICT},
    '{ROW_WORD, MODE_MAP,     1'b0, 8'd255, GAIN_POS, 10'sd255}
  };

  // DUT ports; every input holds a known value from time 0.
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                gain_sign_we_i  = 1'b0;
  logic signed [1:0]   gain_sign_i     = GAIN_POS;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic                mode_i          = MODE_MEASURE;
  logic                first_of_pass_i = 1'b0;
  logic [SAMPLE_W-1:0] sample_i        = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [SAMPLE_W-1:0] out_sample_o;

  // Predictor state: extremes, reciprocal and gain, kept beside the block's own.
  logic [SAMPLE_W-1:0]  seen_lo = 8'd255;
  logic [SAMPLE_W-1:0]  seen_hi = 8'd0;
  logic [RECIP_W-1:0]   recip_q = '0;
  logic signed [1:0]    gain_q  = GAIN_POS;
  longint unsigned      ln_lut [256];

  logic [SAMPLE_W-1:0]  pixel_due_q [$];
  int unsigned          mismatches = 0;
  int unsigned          words_sent = 0;

  // Idle knobs: tx_idle_pct is read by the sending process only.
  int unsigned          tx_idle_pct  = 10;
  int unsigned          rx_stall_pct = 88;
  int unsigned          stall_token  = 0;
  int unsigned          stall_seen   = 0;
  int unsigned          stall_left   = 0;

  log_transform_minmax_normalize_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .gain_sign_we_i  (gain_sign_we_i),
    .gain_sign_i     (gain_sign_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .first_of_pass_i (first_of_pass_i),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_sample_o    (out_sample_o)
  );

  always #2 clk_i = ~clk_i;

  // ln(x) for x in 1..256 with LOG_FRAC_BITS fraction bits: log2 by squaring
  // the normalized mantissa, then scale by ln2 and round half up.
  function automatic longint unsigned ln_fixed(int unsigned x);
    int unsigned     ex;
    longint unsigned mant;
    longint unsigned frac_bits;
    ex = 0;
    while (ex < 8 && (x >> (ex + 1)) != 0) begin
      ex++;
    end
    mant      = 64'(x) << (30 - ex);
    frac_bits = 0;
    repeat (24) begin
      mant      = (mant * mant) >> 30;
      frac_bits = frac_bits << 1;
      if (mant >= 64'h8000_0000) begin
        mant      = mant >> 1;
        frac_bits = frac_bits | 64'd1;
      end
    end
    mant = ((64'(ex) << 24) | frac_bits) * LN2_SCALE;
    return (mant + (64'd1 << (55 - LOG_FRAC_BITS))) >> (56 - LOG_FRAC_BITS);
  endfunction

  // Advance the predictor by one accepted word; queue the output of a map word.
  // A typed value from the table overrides the computed one.
  function automatic void map_predict(logic m, logic f, logic [SAMPLE_W-1:0] s,
                                      logic signed [9:0] want);
    longint unsigned l_p;
    longint unsigned l_lo;
    longint unsigned l_hi;
    longint unsigned span;
    longint unsigned n;
    longint unsigned v;
    if (m == MODE_MEASURE) begin
      if (f) begin
        seen_lo = s;
        seen_hi = s;
      end else begin
        if (s < seen_lo) seen_lo = s;
        if (s > seen_hi) seen_hi = s;
      end
      return;
    end
    l_p  = ln_lut[s];
    l_lo = ln_lut[seen_lo];
    l_hi = ln_lut[seen_hi];
    // The first map word of a pass refreshes the reciprocal of the log range.
    if (f) begin
      if (l_hi <= l_lo) begin
        recip_q = '0;
      end else begin
        span    = l_hi - l_lo;
        v       = ((64'd255 << (LOG_FRAC_BITS + 8)) + (span >> 1)) / span;
        recip_q = (v > 64'(RECIP_MAX)) ? RECIP_MAX : v[RECIP_W-1:0];
      end
    end
    if (gain_q == GAIN_ZERO) begin
      v = 0;
    end else begin
      if (gain_q[GAIN_NEG_BIT]) begin
        n = (l_hi > l_p) ? l_hi - l_p : 64'd0;
      end else begin
        n = (l_p > l_lo) ? l_p - l_lo : 64'd0;
      end
      v = (n * 64'(recip_q) + (64'd1 << (LOG_FRAC_BITS + 7))) >> (LOG_FRAC_BITS + 8);
      if (v > 64'd255) v = 64'd255;
    end
    pixel_due_q.push_back((want == PREDICT) ? 8'(v) : 8'(want));
  endfunction

  // Offer one word, after a random idle gap; return at the edge that takes it.
  // Valid stays high between back-to-back words.
  task automatic send_word(input logic m, input logic f, input logic [SAMPLE_W-1:0] s,
                           input logic signed [9:0] want);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= m;
    first_of_pass_i <= f;
    sample_i        <= s;
    do @(posedge clk_i); while (!in_ready_o);
    map_predict(m, f, s, want);
    words_sent++;
  endtask

  // Drop valid and hold off until every queued output has come, then settle.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the gain register; only called with the block drained.
  task automatic write_gain(input logic signed [1:0] g);
    gain_sign_we_i <= 1'b1;
    gain_sign_i    <= g;
    @(posedge clk_i);
    gain_sign_we_i <= 1'b0;
    gain_q = g;
  endtask

  // One random frame: a measure pass over a band, then a map pass of the same
  // length. Mostly well formed; sometimes drop a first flag, skip the measure
  // pass, or slip in a stray measure word.
  task automatic run_frame();
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    int unsigned tmp;
    logic [SAMPLE_W-1:0] s;
    len = ($urandom_range(15) == 0) ? $urandom_range(48, 24) : $urandom_range(10, 1);
    lo  = $urandom_range(255);
    hi  = $urandom_range(255);
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    if ($urandom_range(7) == 0) begin
      hi = lo;
    end else if ($urandom_range(7) == 0) begin
      lo = 0;
      hi = 255;
    end
    if ($urandom_range(9) != 0) begin
      for (int k = 0; k < len; k++) begin
        s = 8'($urandom_range(hi, lo));
        send_word(MODE_MEASURE, (k == 0) && ($urandom_range(11) != 0), s, PREDICT);
      end
    end
    if ($urandom_range(5) == 0) begin
      send_word(MODE_MEASURE, 1'($urandom_range(1)), 8'($urandom), PREDICT);
    end
    for (int k = 0; k < len; k++) begin
      s = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(hi, lo));
      send_word(MODE_MAP, (k == 0) && ($urandom_range(11) != 0), s, PREDICT);
    end
  endtask

  // Output side: check each taken word against the oldest expectation, then
  // choose ready for the next edge. A new stall token holds ready low for a
  // long stretch so the block backs up into its input.
  always @(posedge clk_i) begin
    logic [SAMPLE_W-1:0] exp_sample;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_due_q.size() == 0) begin
        $display("%0t: out_sample with nothing expected, actual %0d", $time, out_sample_o);
        mismatches++;
      end else begin
        exp_sample = pixel_due_q.pop_front();
        if (out_sample_o !== exp_sample) begin
          $display("%0t: out_sample expected %0d actual %0d", $time, exp_sample,
                   out_sample_o);
          mismatches++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stall_token != stall_seen) begin
      stall_seen  <= stall_token;
      stall_left  <= RX_HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Stimulus: reset, directed table, then three idling phases of random frames.
  initial begin
    int unsigned target;
    dir_row_t    row;
    for (int p = 0; p < 256; p++) begin
      ln_lut[p] = ln_fixed(p + 1);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_GAIN) begin
        drain_block();
        write_gain(row.gain);
      end else begin
        send_word(row.mode, row.first, row.value, row.want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      drain_block();
      case (ph)
        0: begin
          tx_idle_pct = 10;
          rx_stall_pct <= 88;
        end
        1: begin
          tx_idle_pct = 88;
          rx_stall_pct <= 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
          stall_token <= stall_token + 1;
        end
      endcase
      target = words_sent + RANDOM_WORDS / 3;
      while (words_sent < target) begin
        // Change the gain now and then, only with the block drained.
        if ($urandom_range(3) == 0) begin
          drain_block();
          case ($urandom_range(5))
            0:       write_gain(GAIN_ZERO);
            1:       write_gain(GAIN_NEG);
            2:       write_gain(GAIN_NEG_ALT);
            default: write_gain(GAIN_POS);
          endcase
        end
        run_frame();
      end
    end

    drain_block();
    if (mismatches == 0 && pixel_due_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
